FILE: design/nearest_neighbor_thumbnail_scaler_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the scaler checker
// ---------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_THUMBNAIL_SCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_THUMBNAIL_SCALER_MACROS_SVH

// same-cycle implication, idle during reset
`define NNTS_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("scaler check failed");

// next-cycle implication, idle during reset
`define NNTS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("scaler check failed");

`endif

FILE: design/nnts_pkg.sv
// ---------------------------------------------------------------------------
// nnts_pkg
// types, register codes and pixel conversion for the thumbnail scaler
// ---------------------------------------------------------------------------
package nnts_pkg;

    typedef logic [31:0] pixel_t;
    typedef logic [13:0] size_t;
    typedef logic [1:0]  cfg_index_t;

    localparam int XY_W = 7;

    // configuration register indexes
    localparam cfg_index_t CFG_SRC_WIDTH    = 2'd0;
    localparam cfg_index_t CFG_SRC_HEIGHT   = 2'd1;
    localparam cfg_index_t CFG_PIXEL_FORMAT = 2'd2;

    // pixel formats
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_XRGB8888 = 1'b1;

    localparam size_t SRC_WIDTH_RST  = 14'd1024;
    localparam size_t SRC_HEIGHT_RST = 14'd768;
    localparam size_t SRC_MAX        = 14'd8192;

    localparam pixel_t RGB565_R_MASK = 32'h0000_F800;
    localparam pixel_t RGB565_G_MASK = 32'h0000_07E0;
    localparam pixel_t RGB565_B_MASK = 32'h0000_001F;
    localparam pixel_t ALPHA_OPAQUE  = 32'hFF00_0000;

    function automatic size_t clamp_size(size_t v, size_t lo);
        size_t r;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > SRC_MAX)
        begin
            r = SRC_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic pixel_t to_argb(pixel_t p, logic fmt);
        pixel_t r;
        if (fmt == FMT_RGB565)
        begin
            r = ALPHA_OPAQUE | ((p & RGB565_R_MASK) << 8) |
                ((p & RGB565_G_MASK) << 5) | ((p & RGB565_B_MASK) << 3);
        end
        else
        begin
            r = ALPHA_OPAQUE | p;
        end
        return r;
    endfunction

endpackage

FILE: design/nearest_neighbor_thumbnail_scaler.sv
// ---------------------------------------------------------------------------
// nearest_neighbor_thumbnail_scaler
// picks thumbnail pixels out of a raster source stream, converts to ARGB8888
// ---------------------------------------------------------------------------
//  port group   dir   handshake          payload
//  source in    in    in_valid/in_ready  pixel_value
//  result out   out   out_valid/out_ready argb_pixel, out_x, out_y, frame_end
//  config       in    cfg_we             cfg_index, cfg_data
//
//  one source pixel per clock while in_ready is high; a selected pixel appears in
//  the cycle after its transfer, set by the single output register
//  in_ready drops only while a result sits in the output register unread
//  rst_n clears counters, accumulators, config to defaults and out_valid
//  row/column selection compares the accumulator against source_index*OUT
//  kept as a running sum, so no divider is needed
// ---------------------------------------------------------------------------
module nearest_neighbor_thumbnail_scaler #(
    parameter int OUT_WIDTH  = 128,
    parameter int OUT_HEIGHT = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nnts_pkg::pixel_t      pixel_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nnts_pkg::pixel_t      argb_pixel,
    output logic [6:0]            out_x,
    output logic [6:0]            out_y,
    output logic                  frame_end,
    input  logic                  cfg_we,
    input  nnts_pkg::cfg_index_t  cfg_index,
    input  nnts_pkg::size_t       cfg_data
);

    localparam int XY_W = nnts_pkg::XY_W;
    localparam int TCW  = $clog2(OUT_WIDTH + 1);
    localparam int TRW  = $clog2(OUT_HEIGHT + 1);
    localparam int CAW  = $clog2(OUT_WIDTH * 8192 + 1);
    localparam int RAW  = $clog2(OUT_HEIGHT * 8192 + 1);

    // configuration
    nnts_pkg::size_t src_width_reg;
    nnts_pkg::size_t src_height_reg;
    logic            pixel_format_reg;

    // scan state
    logic [12:0]    src_col_reg,    src_col_next;
    logic [12:0]    src_row_reg,    src_row_next;
    logic [CAW-1:0] col_scaled_reg, col_scaled_next;
    logic [RAW-1:0] row_scaled_reg, row_scaled_next;
    logic [TCW-1:0] thumb_col_reg,  thumb_col_next;
    logic [TRW-1:0] thumb_row_reg,  thumb_row_next;
    logic [CAW-1:0] col_acc_reg,    col_acc_next;
    logic [RAW-1:0] row_acc_reg,    row_acc_next;

    // output register
    logic             out_valid_reg;
    nnts_pkg::pixel_t argb_reg;
    logic [XY_W-1:0]  out_x_reg;
    logic [XY_W-1:0]  out_y_reg;
    logic             frame_end_reg;

    nnts_pkg::size_t w_eff;
    nnts_pkg::size_t h_eff;
    logic [CAW-1:0]  col_diff;
    logic [RAW-1:0]  row_diff;
    logic            col_hit;
    logic            row_hit;
    logic            accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    assign w_eff = nnts_pkg::clamp_size(src_width_reg,  nnts_pkg::size_t'(OUT_WIDTH));
    assign h_eff = nnts_pkg::clamp_size(src_height_reg, nnts_pkg::size_t'(OUT_HEIGHT));

    // column == floor(acc / OUT) <=> 0 <= acc - column*OUT < OUT
    assign col_diff = col_acc_reg - col_scaled_reg;
    assign row_diff = row_acc_reg - row_scaled_reg;
    assign col_hit  = (thumb_col_reg < TCW'(OUT_WIDTH)) && (col_acc_reg >= col_scaled_reg) &&
                      (col_diff < CAW'(OUT_WIDTH));
    assign row_hit  = (thumb_row_reg < TRW'(OUT_HEIGHT)) && (row_acc_reg >= row_scaled_reg) &&
                      (row_diff < RAW'(OUT_HEIGHT));

    always_comb
    begin
        src_col_next    = src_col_reg;
        src_row_next    = src_row_reg;
        col_scaled_next = col_scaled_reg;
        row_scaled_next = row_scaled_reg;
        thumb_col_next  = thumb_col_reg;
        thumb_row_next  = thumb_row_reg;
        col_acc_next    = col_acc_reg;
        row_acc_next    = row_acc_reg;

        if (row_hit && col_hit)
        begin
            thumb_col_next = thumb_col_reg + TCW'(1);
            col_acc_next   = col_acc_reg + CAW'(w_eff);
        end

        if ({1'b0, src_col_reg} >= (w_eff - 14'd1))
        begin
            // end of source row
            src_col_next    = '0;
            col_scaled_next = '0;
            thumb_col_next  = '0;
            col_acc_next    = '0;
            if ({1'b0, src_row_reg} >= (h_eff - 14'd1))
            begin
                src_row_next    = '0;
                row_scaled_next = '0;
                thumb_row_next  = '0;
                row_acc_next    = '0;
            end
            else
            begin
                src_row_next    = src_row_reg + 13'd1;
                row_scaled_next = row_scaled_reg + RAW'(OUT_HEIGHT);
                if (row_hit)
                begin
                    thumb_row_next = thumb_row_reg + TRW'(1);
                    row_acc_next   = row_acc_reg + RAW'(h_eff);
                end
            end
        end
        else
        begin
            src_col_next    = src_col_reg + 13'd1;
            col_scaled_next = col_scaled_reg + CAW'(OUT_WIDTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= nnts_pkg::SRC_WIDTH_RST;
            src_height_reg   <= nnts_pkg::SRC_HEIGHT_RST;
            pixel_format_reg <= nnts_pkg::FMT_XRGB8888;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                nnts_pkg::CFG_SRC_WIDTH:    src_width_reg    <= cfg_data;
                nnts_pkg::CFG_SRC_HEIGHT:   src_height_reg   <= cfg_data;
                nnts_pkg::CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            col_scaled_reg <= '0;
            row_scaled_reg <= '0;
            thumb_col_reg  <= '0;
            thumb_row_reg  <= '0;
            col_acc_reg    <= '0;
            row_acc_reg    <= '0;
        end
        else if (accept)
        begin
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            col_scaled_reg <= col_scaled_next;
            row_scaled_reg <= row_scaled_next;
            thumb_col_reg  <= thumb_col_next;
            thumb_row_reg  <= thumb_row_next;
            col_acc_reg    <= col_acc_next;
            row_acc_reg    <= row_acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= accept && row_hit && col_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && row_hit && col_hit)
        begin
            argb_reg      <= nnts_pkg::to_argb(pixel_value, pixel_format_reg);
            out_x_reg     <= XY_W'(thumb_col_reg);
            out_y_reg     <= XY_W'(thumb_row_reg);
            frame_end_reg <= (thumb_col_reg == TCW'(OUT_WIDTH - 1)) &&
                             (thumb_row_reg == TRW'(OUT_HEIGHT - 1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign argb_pixel = argb_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign frame_end  = frame_end_reg;

endmodule

FILE: design/nnts_checker.sv
// ---------------------------------------------------------------------------
// nnts_checker
// port-level checks on the thumbnail scaler, bound to the top level
// ---------------------------------------------------------------------------
`include "nearest_neighbor_thumbnail_scaler_macros.svh"

module nnts_checker #(
    parameter int OUT_WIDTH  = 128,
    parameter int OUT_HEIGHT = 128
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input nnts_pkg::pixel_t     argb_pixel,
    input logic [6:0]           out_x,
    input logic [6:0]           out_y,
    input logic                 frame_end
);

    localparam logic [6:0] LAST_X = 7'(OUT_WIDTH - 1);
    localparam logic [6:0] LAST_Y = 7'(OUT_HEIGHT - 1);

    logic        out_stall;
    logic [46:0] out_word;
    logic        at_last_pos;

    assign out_stall   = out_valid && !out_ready;
    assign out_word    = {argb_pixel, out_x, out_y, frame_end};
    assign at_last_pos = (out_x == LAST_X) && (out_y == LAST_Y);

    // a stalled result holds
    `NNTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

    // an empty output register never blocks the source side
    `NNTS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // every result is opaque
    `NNTS_ASSERT_NOW(a_alpha_opaque, clk, rst_n, out_valid, argb_pixel[31:24] == 8'hFF)

    // frame end only on the last thumbnail position
    `NNTS_ASSERT_NOW(a_frame_end_pos, clk, rst_n, out_valid && frame_end, at_last_pos)

endmodule

bind nearest_neighbor_thumbnail_scaler nnts_checker #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
) u_nnts_checker (.*);
